FILE: rtl/u8d_pkg.sv
`default_nettype none

package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned StW   = 2;

  // Result status codes.
  localparam logic [StW-1:0] ST_OK        = 2'd0;
  localparam logic [StW-1:0] ST_BAD_LEAD  = 2'd1;
  localparam logic [StW-1:0] ST_TRUNCATED = 2'd2;
  localparam logic [StW-1:0] ST_TOO_LARGE = 2'd3;

  // Lead byte classes.
  typedef enum logic [2:0] {
    LEAD_BAD   = 3'd0,
    LEAD_ONE   = 3'd1,
    LEAD_TWO   = 3'd2,
    LEAD_THREE = 3'd3,
    LEAD_FOUR  = 3'd4
  } lead_e;

  function automatic lead_e lead_class(input logic [ByteW-1:0] b);
    lead_e res;
    if (b < 8'h80) begin
      res = LEAD_ONE;
    end else if (b < 8'hC2) begin
      res = LEAD_BAD;
    end else if (b < 8'hE0) begin
      res = LEAD_TWO;
    end else if (b < 8'hF0) begin
      res = LEAD_THREE;
    end else if (b < 8'hF5) begin
      res = LEAD_FOUR;
    end else begin
      res = LEAD_BAD;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/u8d_byte_if.sv
`default_nettype none

interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/u8d_cp_if.sv
`default_nettype none

interface u8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output code_point, output status, output last_result,
                  input ready);
  modport sink   (input valid, input code_point, input status, input last_result,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8_stream_decoder.sv
// Channel   | Direction | Payload                                  | Handshake
// byte_i    | in        | data_byte[7:0], end_of_string            | valid/ready
// cp_o      | out       | code_point[20:0], status[1:0], last_result | valid/ready
// cfg       | in        | cfg_we_i, cfg_data_i (output_mode)       | write enable only
//
// One byte is accepted per clock when the output side keeps up. A byte is
// held in an input register, is decoded against the sequence state and, if it
// completes a character or raises an error, lands in the result register,
// which drives the result transaction on cp_o.
// The single decode step between those two registers sets the rate of one byte
// per clock. A stall on cp_o holds the result register and the input register;
// ready on byte_i falls only when both are full and the result is not taken.
// Reset (rst_ni low, asynchronous) empties both registers, clears the sequence
// state and returns output_mode to full code points.

`default_nettype none

module utf8_stream_decoder (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  u8d_byte_if.sink    byte_i,
  u8d_cp_if.source    cp_o,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_data_i
);
  import u8d_pkg::*;

  // Input register.
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // Sequence state.
  logic [1:0]       rem_q, rem_d;
  logic [CpW-1:0]   part_q, part_d;
  logic             disc_q, disc_d;
  logic             mode_q;

  // Result register.
  logic             out_valid_q;
  logic [CpW-1:0]   out_cp_q;
  logic [StW-1:0]   out_st_q;
  logic             out_last_q;

  logic             adv;
  logic             emit;
  logic [CpW-1:0]   emit_cp;
  logic [StW-1:0]   emit_st;
  logic [CpW-1:0]   shifted;
  lead_e            lead;

  // The decode step fires when a byte waits and the result register is free
  // or being emptied in this cycle.
  assign adv          = in_valid_q && (!out_valid_q || cp_o.ready);
  assign byte_i.ready = !in_valid_q || adv;

  assign lead    = lead_class(in_byte_q);
  assign shifted = {part_q[CpW-7:0], in_byte_q[5:0]};

  always_comb begin
    rem_d   = rem_q;
    part_d  = part_q;
    disc_d  = disc_q;
    emit    = 1'b0;
    emit_cp = '0;
    emit_st = ST_OK;

    if (disc_q) begin
      // Dropping the rest of a string after an error; its last byte ends that.
      if (in_last_q) begin
        disc_d = 1'b0;
      end
    end else if (rem_q == 2'd0) begin
      case (lead)
        LEAD_ONE: begin
          emit    = 1'b1;
          emit_cp = {{(CpW-ByteW){1'b0}}, in_byte_q};
        end
        LEAD_BAD: begin
          emit    = 1'b1;
          emit_st = ST_BAD_LEAD;
        end
        LEAD_TWO, LEAD_THREE, LEAD_FOUR: begin
          if (lead == LEAD_FOUR && mode_q) begin
            emit    = 1'b1;
            emit_st = ST_TOO_LARGE;
          end else if (in_last_q) begin
            // A multi-byte lead that closes the string is cut short.
            emit    = 1'b1;
            emit_st = ST_TRUNCATED;
          end else begin
            case (lead)
              LEAD_TWO: begin
                part_d = {{(CpW-5){1'b0}}, in_byte_q[4:0]};
                rem_d  = 2'd1;
              end
              LEAD_THREE: begin
                part_d = {{(CpW-4){1'b0}}, in_byte_q[3:0]};
                rem_d  = 2'd2;
              end
              default: begin
                part_d = {{(CpW-3){1'b0}}, in_byte_q[2:0]};
                rem_d  = 2'd3;
              end
            endcase
          end
        end
        default: begin
          emit    = 1'b1;
          emit_st = ST_BAD_LEAD;
        end
      endcase
    end else if (in_byte_q == '0) begin
      // A zero byte inside a sequence truncates it.
      emit    = 1'b1;
      emit_st = ST_TRUNCATED;
    end else if (rem_q == 2'd1) begin
      emit    = 1'b1;
      emit_cp = shifted;
      rem_d   = 2'd0;
      part_d  = '0;
    end else if (in_last_q) begin
      emit    = 1'b1;
      emit_st = ST_TRUNCATED;
    end else begin
      part_d = shifted;
      rem_d  = rem_q - 2'd1;
    end

    // Every error result clears the sequence, and starts discarding unless
    // the faulty byte was already the last of its string.
    if (emit && emit_st != ST_OK) begin
      rem_d  = 2'd0;
      part_d = '0;
      disc_d = !in_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= 2'd0;
      part_q      <= '0;
      disc_q      <= 1'b0;
      mode_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      if (adv) begin
        rem_q  <= rem_d;
        part_q <= part_d;
        disc_q <= disc_d;
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (cp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.end_of_string;
    end
    if (adv && emit) begin
      out_cp_q   <= emit_cp;
      out_st_q   <= emit_st;
      out_last_q <= in_last_q;
    end
  end

  assign cp_o.valid       = out_valid_q;
  assign cp_o.code_point  = out_cp_q;
  assign cp_o.status      = out_st_q;
  assign cp_o.last_result = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/u8d_checker.sv
`default_nettype none

module u8d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cp_valid_i,
  input wire logic        cp_ready_i,
  input wire logic [20:0] cp_code_point_i,
  input wire logic [1:0]  cp_status_i,
  input wire logic        cp_last_i
);
  import u8d_pkg::*;

  // Error results never carry a character value.
  a_err_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cp_valid_i && cp_status_i != ST_OK) |-> (cp_code_point_i == '0))
    else $error("error result with non-zero code point");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cp_valid_i && !cp_ready_i) |=>
      (cp_valid_i && $stable(cp_code_point_i) && $stable(cp_status_i)
       && $stable(cp_last_i)))
    else $error("stalled result changed");

  // Nothing is offered while reset is held.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !cp_valid_i)
    else $error("result offered during reset");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cp_valid_i      (cp_o.valid),
  .cp_ready_i      (cp_o.ready),
  .cp_code_point_i (cp_o.code_point),
  .cp_status_i     (cp_o.status),
  .cp_last_i       (cp_o.last_result)
);

`default_nettype wire
